### rtl/core/madws_pkg.sv
// Shared types and constants for the minimum separated difference unit.
package madws_pkg;

    localparam int MAX_ITEMS_DEF  = 1024;
    localparam int VALUE_BITS_DEF = 30;
    localparam int SEP_BITS       = 10;
    localparam logic [SEP_BITS-1:0] SEP_RESET = SEP_BITS'(1);

    // Control bits of one request wave travelling down the cell row.
    typedef struct packed {
        logic valid;   // wave carries a request
        logic ins;     // insert value still in flight
        logic qry;     // nearest-value search active
        logic last;    // final request of the sequence
        logic ovf;     // request arrived past capacity
        logic dfound;  // running difference is meaningful
    } t_wave;

endpackage

### rtl/core/madws_front.sv
// Input stage: separation register, position counter and delay line memory.
module madws_front
    import madws_pkg::*;
#(
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [SEP_BITS-1:0]   i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [VALUE_BITS-1:0] i_value_in,
    input  logic                  i_last_in,
    input  logic                  i_adv,
    output t_wave                 o_ctl,
    output logic [VALUE_BITS-1:0] o_ins_val,
    output logic [VALUE_BITS-1:0] o_qry_val
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int PW = $clog2(MAX_ITEMS + 1);
    localparam int CW = (PW > SEP_BITS) ? PW : SEP_BITS;

    logic [SEP_BITS-1:0]   r_sep;
    logic [PW-1:0]         r_pos;
    logic                  r_fv;
    t_wave                 r_ctl;
    logic [VALUE_BITS-1:0] r_v;
    logic [VALUE_BITS-1:0] r_rd;
    logic [VALUE_BITS-1:0] r_mem [MAX_ITEMS];

    logic [SEP_BITS-1:0] sep;
    logic [CW-1:0]       pos_x;
    logic [CW-1:0]       sep_x;
    logic                in_range;
    logic                eligible;
    logic                accept;
    logic [AW-1:0]       raddr;
    logic [AW-1:0]       waddr;
    t_wave               n_ctl;

    assign sep      = (r_sep == '0) ? SEP_BITS'(1) : r_sep;
    assign pos_x    = CW'(r_pos);
    assign sep_x    = CW'(sep);
    assign in_range = r_pos < PW'(MAX_ITEMS);
    assign eligible = in_range && (pos_x >= sep_x);
    assign raddr    = AW'(pos_x - sep_x);
    assign waddr    = AW'(r_pos);

    assign o_in_ready = !r_fv || i_adv;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_ctl        = '0;
        n_ctl.valid  = 1'b1;
        n_ctl.ins    = eligible;
        n_ctl.qry    = eligible;
        n_ctl.last   = i_last_in;
        n_ctl.ovf    = !in_range;
        n_ctl.dfound = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep <= SEP_RESET;
            r_pos <= '0;
            r_fv  <= 1'b0;
            r_ctl <= '0;
        end else begin
            if (i_cfg_we) begin
                r_sep <= i_cfg_wdata;
            end
            if (accept) begin
                r_fv  <= 1'b1;
                r_ctl <= n_ctl;
                if (i_last_in) begin
                    r_pos <= '0;
                end else if (in_range) begin
                    r_pos <= r_pos + PW'(1);
                end
            end else if (i_adv) begin
                r_fv  <= 1'b0;
                r_ctl <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && in_range) begin
            r_mem[waddr] <= i_value_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= r_mem[raddr];
            r_v  <= i_value_in;
        end
    end

    assign o_ctl     = r_ctl;
    assign o_ins_val = r_rd;
    assign o_qry_val = r_v;

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(MAX_ITEMS))
        else $error("position counter past capacity");

    a_ovf_no_ins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !in_range) |=> (r_ctl.ovf && !r_ctl.ins && !r_ctl.qry))
        else $error("overflow request entered the store");

endmodule

### rtl/core/madws_cell.sv
// One sorted cell: holds one stored value, inserts in order, tracks nearest difference.
module madws_cell
    import madws_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  t_wave                 i_ctl,
    input  logic [VALUE_BITS-1:0] i_ins_val,
    input  logic [VALUE_BITS-1:0] i_qry_val,
    input  logic [VALUE_BITS-1:0] i_dmin,
    output t_wave                 o_ctl,
    output logic [VALUE_BITS-1:0] o_ins_val,
    output logic [VALUE_BITS-1:0] o_qry_val,
    output logic [VALUE_BITS-1:0] o_dmin
);

    logic                  r_full;
    logic [VALUE_BITS-1:0] r_val;
    t_wave                 r_ctl;
    logic [VALUE_BITS-1:0] r_ins_val;
    logic [VALUE_BITS-1:0] r_qry_val;
    logic [VALUE_BITS-1:0] r_dmin;

    logic                  n_full;
    logic [VALUE_BITS-1:0] n_val;
    t_wave                 n_ctl;
    logic [VALUE_BITS-1:0] n_ins_val;
    logic [VALUE_BITS-1:0] n_dmin;
    logic [VALUE_BITS-1:0] diff;
    logic                  take;

    always_comb begin
        n_val     = r_val;
        n_full    = r_full;
        n_ctl     = i_ctl;
        n_ctl.ins = 1'b0;
        n_ins_val = i_ins_val;
        if (i_ctl.valid && i_ctl.ins) begin
            if (!r_full) begin
                n_val  = i_ins_val;
                n_full = 1'b1;
            end else if (i_ins_val < r_val) begin
                n_val     = i_ins_val;
                n_ins_val = r_val;
                n_ctl.ins = 1'b1;
            end else begin
                n_ctl.ins = 1'b1;
            end
        end
        diff = (n_val >= i_qry_val) ? (n_val - i_qry_val) : (i_qry_val - n_val);
        take = i_ctl.valid && i_ctl.qry && n_full && (!i_ctl.dfound || (diff < i_dmin));
        n_dmin       = take ? diff : i_dmin;
        n_ctl.dfound = i_ctl.dfound || take;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
            r_ctl  <= '0;
        end else if (i_adv) begin
            r_full <= (i_ctl.valid && i_ctl.last) ? 1'b0 : n_full;
            r_ctl  <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_val     <= n_val;
            r_ins_val <= n_ins_val;
            r_qry_val <= i_qry_val;
            r_dmin    <= n_dmin;
        end
    end

    assign o_ctl     = r_ctl;
    assign o_ins_val = r_ins_val;
    assign o_qry_val = r_qry_val;
    assign o_dmin    = r_dmin;

    a_full_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full && i_adv && i_ctl.valid && i_ctl.ins) |=> r_ctl.ins)
        else $error("insert into occupied cell lost a value");

endmodule

### rtl/core/min_abs_diff_with_separation_unit.sv
// Top level: delay line front end, row of sorted cells and running-minimum result stage.
//
// Each request enters the front stage, where its value is written to the delay line and
// the value min_separation positions back is read. The request then travels as a wave
// through MAX_ITEMS sorted cells, one cell per cycle: each cell performs its part of the
// ordered insert and folds its stored value into the running nearest difference. A new
// request is accepted every cycle while the result side keeps up, and each result is
// registered in the front stage, in every cell of the row and in the result stage before
// it appears. Stalling the result side freezes the whole row. The store is emptied by
// the wave of the request that carries last, so a new sequence can follow immediately.
module min_abs_diff_with_separation_unit
    import madws_pkg::*;
#(
    parameter int MAX_ITEMS  = MAX_ITEMS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [SEP_BITS-1:0]   i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [VALUE_BITS-1:0] i_value_in,
    input  logic                  i_last_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [VALUE_BITS-1:0] o_best_difference,
    output logic                  o_found,
    output logic                  o_overflow,
    output logic                  o_last_out
);

    t_wave                 w_ctl     [MAX_ITEMS+1];
    logic [VALUE_BITS-1:0] w_ins_val [MAX_ITEMS+1];
    logic [VALUE_BITS-1:0] w_qry_val [MAX_ITEMS+1];
    logic [VALUE_BITS-1:0] w_dmin    [MAX_ITEMS+1];

    logic                  adv;
    logic                  fire;
    t_wave                 tail;

    logic                  r_out_valid;
    logic [VALUE_BITS-1:0] r_out_best;
    logic                  r_out_found;
    logic                  r_out_ovf;
    logic                  r_out_last;
    logic [VALUE_BITS-1:0] r_best;
    logic                  r_found;
    logic                  r_ovf;

    logic [VALUE_BITS-1:0] n_best;
    logic                  n_found;
    logic                  n_ovf;

    assign adv = !r_out_valid || i_out_ready;

    madws_front #(
        .MAX_ITEMS  (MAX_ITEMS),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_value_in  (i_value_in),
        .i_last_in   (i_last_in),
        .i_adv       (adv),
        .o_ctl       (w_ctl[0]),
        .o_ins_val   (w_ins_val[0]),
        .o_qry_val   (w_qry_val[0])
    );

    assign w_dmin[0] = '0;

    for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
        madws_cell #(
            .VALUE_BITS (VALUE_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_adv     (adv),
            .i_ctl     (w_ctl[k]),
            .i_ins_val (w_ins_val[k]),
            .i_qry_val (w_qry_val[k]),
            .i_dmin    (w_dmin[k]),
            .o_ctl     (w_ctl[k+1]),
            .o_ins_val (w_ins_val[k+1]),
            .o_qry_val (w_qry_val[k+1]),
            .o_dmin    (w_dmin[k+1])
        );
    end

    assign tail = w_ctl[MAX_ITEMS];
    assign fire = adv && tail.valid;

    always_comb begin
        n_best  = r_best;
        n_found = r_found;
        n_ovf   = r_ovf;
        if (tail.ovf) begin
            n_ovf = 1'b1;
        end else if (tail.dfound && (!r_found || (w_dmin[MAX_ITEMS] < r_best))) begin
            n_best  = w_dmin[MAX_ITEMS];
            n_found = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_best      <= '0;
            r_found     <= 1'b0;
            r_ovf       <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
            if (tail.last) begin
                r_best  <= '0;
                r_found <= 1'b0;
                r_ovf   <= 1'b0;
            end else begin
                r_best  <= n_best;
                r_found <= n_found;
                r_ovf   <= n_ovf;
            end
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_best  <= n_found ? n_best : '0;
            r_out_found <= n_found;
            r_out_ovf   <= n_ovf;
            r_out_last  <= tail.last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_best_difference = r_out_best;
    assign o_found           = r_out_found;
    assign o_overflow        = r_out_ovf;
    assign o_last_out        = r_out_last;

    a_seq_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && tail.last) |=> (!r_found && !r_ovf))
        else $error("sequence state not cleared after last request");

    a_best_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_best_difference == '0))
        else $error("difference reported without a pair");

endmodule

### tb/testbench.sv
// Testbench for the minimum separated difference unit, checked against a behavioral model.
`timescale 1ns / 1ps

module testbench;
    import madws_pkg::*;

    localparam int VB          = VALUE_BITS_DEF;
    localparam int DEPTH       = MAX_ITEMS_DEF;
    localparam int HOLD_CYCLES = 2000;
    localparam int TAIL_CYCLES = DEPTH + 80;

    typedef logic [VB-1:0]       value_t;
    typedef logic [SEP_BITS-1:0] sep_t;

    typedef struct packed {
        value_t diff;
        logic   found;
        logic   ovf;
        logic   last;
    } diff_result_t;

    typedef enum int {
        VAL_FULL,
        VAL_LOW,
        VAL_HIGH,
        VAL_CLUSTER,
        VAL_BITS
    } val_mode_t;

    // Running nearest-difference model plus the queue of results still owed by the block.
    class nearest_diff_board;
        value_t       delay_line [DEPTH];
        value_t       sorted_vals[$];
        int unsigned  position;
        value_t       best;
        logic         have_pair;
        logic         overflowed;
        sep_t         separation;
        diff_result_t owed[$];
        int           errors;

        function new();
            sorted_vals.delete();
            owed.delete();
            position   = 0;
            best       = '0;
            have_pair  = 1'b0;
            overflowed = 1'b0;
            separation = SEP_RESET;
            errors     = 0;
        endfunction

        function void load_sep(sep_t s);
            separation = s;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function int unsigned count_below(value_t v);
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            lo = 0;
            hi = sorted_vals.size();
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (sorted_vals[mid] < v) begin
                    lo = mid + 1;
                end else begin
                    hi = mid;
                end
            end
            return lo;
        endfunction

        function void fold_diff(value_t d);
            if (!have_pair || d < best) begin
                best      = d;
                have_pair = 1'b1;
            end
        endfunction

        function void take_request(value_t v, logic lst);
            int unsigned  s;
            int unsigned  j;
            int unsigned  at;
            value_t       old_v;
            diff_result_t r;
            s = (separation == 0) ? 1 : separation;
            if (position >= DEPTH) begin
                overflowed = 1'b1;
            end else begin
                j = position;
                delay_line[j] = v;
                if (j >= s) begin
                    old_v = delay_line[j - s];
                    if (sorted_vals.size() < DEPTH) begin
                        at = count_below(old_v);
                        sorted_vals.insert(at, old_v);
                    end
                    at = count_below(v);
                    if (at < sorted_vals.size()) begin
                        fold_diff(sorted_vals[at] - v);
                    end
                    if (at < sorted_vals.size() && sorted_vals[at] == v) begin
                        fold_diff('0);
                    end else if (at > 0) begin
                        fold_diff(v - sorted_vals[at - 1]);
                    end
                end
                position = j + 1;
            end
            r.diff  = have_pair ? best : '0;
            r.found = have_pair;
            r.ovf   = overflowed;
            r.last  = lst;
            owed.push_back(r);
            if (lst) begin
                sorted_vals.delete();
                position   = 0;
                best       = '0;
                have_pair  = 1'b0;
                overflowed = 1'b0;
            end
        endfunction

        function void check_result(diff_result_t got);
            diff_result_t exp_r;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected result: diff=%0d found=%0b ovf=%0b last=%0b",
                             got.diff, got.found, got.ovf, got.last);
                end
                return;
            end
            exp_r = owed.pop_front();
            if (got.diff !== exp_r.diff || got.found !== exp_r.found ||
                got.ovf !== exp_r.ovf || got.last !== exp_r.last) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: diff exp %0d got %0d, found exp %0b got %0b",
                             exp_r.diff, got.diff, exp_r.found, got.found);
                    $display("          ovf exp %0b got %0b, last exp %0b got %0b",
                             exp_r.ovf, got.ovf, exp_r.last, got.last);
                end
            end
        endfunction
    endclass

    logic   clk       = 1'b0;
    logic   rst_n     = 1'b0;
    logic   cfg_we    = 1'b0;
    sep_t   cfg_wdata = '0;
    logic   in_valid  = 1'b0;
    logic   in_ready;
    value_t value_in  = '0;
    logic   last_in   = 1'b0;
    logic   out_valid;
    logic   out_ready = 1'b0;
    value_t best_diff;
    logic   found;
    logic   overflow;
    logic   last_out;

    logic   no_idle    = 1'b0;
    logic   hold_armed = 1'b0;

    nearest_diff_board board;

    min_abs_diff_with_separation_unit u_dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_cfg_we          (cfg_we),
        .i_cfg_wdata       (cfg_wdata),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_value_in        (value_in),
        .i_last_in         (last_in),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_best_difference (best_diff),
        .o_found           (found),
        .o_overflow        (overflow),
        .o_last_out        (last_out)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off when armed.
    initial begin
        forever begin
            @(negedge clk);
            if (hold_armed) begin
                hold_armed = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            out_ready <= no_idle || ($urandom_range(99) >= 27);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            board.check_result('{best_diff, found, overflow, last_out});
        end
    end

    function automatic value_t pick_value(val_mode_t mode);
        value_t v;
        case (mode)
            VAL_FULL:    v = value_t'($urandom);
            VAL_LOW:     v = value_t'($urandom_range(63));
            VAL_HIGH:    v = '1 - value_t'($urandom_range(63));
            VAL_CLUSTER: v = value_t'(30'h2000_0000 + $urandom_range(1023));
            default: begin
                v = value_t'(1) << $urandom_range(VB - 1);
                if ($urandom_range(1)) v = ~v;
            end
        endcase
        return v;
    endfunction

    // Called and returns at a falling edge; the request is held until accepted.
    task automatic send_request(input value_t v, input logic lst);
        if (!no_idle) begin
            while ($urandom_range(99) < 27) begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
        end
        in_valid <= 1'b1;
        value_in <= v;
        last_in  <= lst;
        do @(posedge clk); while (!in_ready);
        board.take_request(v, lst);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending() != 0) @(negedge clk);
    endtask

    task automatic write_sep(input sep_t s);
        cfg_we    <= 1'b1;
        cfg_wdata <= s;
        board.load_sep(s);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_mode(input logic quiet, input logic hold);
        @(posedge clk);
        no_idle    = quiet;
        hold_armed = hold;
        @(negedge clk);
    endtask

    task automatic run_phase(input int count, input int max_len, input logic close_seq);
        int        left;
        int        i;
        val_mode_t mode;
        logic      lst;
        left = $urandom_range(max_len, 1);
        mode = val_mode_t'($urandom_range(4));
        for (i = 0; i < count; i++) begin
            left--;
            lst = (left == 0) || (close_seq && i == count - 1);
            send_request(pick_value(mode), lst);
            if (lst) begin
                left = $urandom_range(max_len, 1);
                mode = val_mode_t'($urandom_range(4));
            end
        end
    endtask

    initial begin
        int   i;
        int   p;
        sep_t s;
        board = new();
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset separation, extremes of the value range, equal pair
        send_request('0, 1'b0);
        send_request('1, 1'b0);
        send_request('0, 1'b0);
        send_request('1, 1'b0);
        send_request(30'h1555_5555, 1'b0);
        send_request(30'h2AAA_AAAA, 1'b0);
        send_request(30'd7, 1'b0);
        send_request(30'd7, 1'b1);
        send_request(30'd123, 1'b1);
        drain();
        write_sep('0);
        send_request(30'd10, 1'b0);
        send_request(30'd20, 1'b0);
        send_request(30'd15, 1'b0);
        send_request(30'd15, 1'b1);
        drain();
        write_sep(sep_t'(3));
        send_request(30'd100, 1'b0);
        send_request(30'd50, 1'b0);
        send_request(30'd75, 1'b0);
        send_request(30'd60, 1'b0);
        send_request(30'd101, 1'b0);
        send_request(30'd49, 1'b1);
        // separation shrinks mid-sequence: an entry never goes into the store
        drain();
        write_sep(sep_t'(2));
        send_request(30'd40, 1'b0);
        send_request(30'd10, 1'b0);
        send_request(30'd30, 1'b0);
        drain();
        write_sep(sep_t'(1));
        send_request(30'd20, 1'b0);
        send_request(30'd35, 1'b1);

        // full-length sequence, then the widest separation, then past capacity
        drain();
        write_sep(sep_t'($urandom_range(8)));
        for (i = 0; i < DEPTH - 1; i++) begin
            send_request(pick_value(val_mode_t'($urandom_range(4))), 1'b0);
        end
        drain();
        write_sep('1);
        for (i = 0; i < 12; i++) begin
            send_request(pick_value(val_mode_t'($urandom_range(4))), i == 11);
        end

        drain();
        write_sep(sep_t'($urandom_range(6, 1)));
        set_mode(1'b1, 1'b0);
        run_phase(60, 20, 1'b1);

        // long result-side hold-off while requests keep coming
        drain();
        set_mode(1'b0, 1'b1);
        write_sep(sep_t'($urandom_range(6, 1)));
        run_phase(900, 40, 1'b1);

        for (p = 0; p < 8; p++) begin
            drain();
            case (p)
                0:       s = '0;
                1:       s = '1;
                2, 3:    s = sep_t'($urandom_range(5, 1));
                default: s = sep_t'($urandom_range(1023));
            endcase
            write_sep(s);
            run_phase($urandom_range(50, 15), 30, p == 7 ? 1'b1 : 1'(($urandom_range(1))));
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/madws_pkg.sv
rtl/core/madws_front.sv
rtl/core/madws_cell.sv
rtl/core/min_abs_diff_with_separation_unit.sv
tb/testbench.sv
